FILE: hdl/c3zp_pkg.sv
package c3zp_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROWS_W     = 16;
    localparam int COLS_W     = 11;
    localparam int KERNEL_W   = 24;
    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = 255;
    localparam int KROWS      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int PROD_W     = 2 * PIX_W + 1;
    localparam int SUM_W      = PROD_W + 4;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int OQ_SUM_W   = OUTQ_CNT_W + 1;

    localparam logic [ROWS_W-1:0]   RST_IMAGE_ROWS    = 16'd256;
    localparam logic [COLS_W-1:0]   RST_IMAGE_COLS    = 11'd256;
    localparam logic [KERNEL_W-1:0] RST_KERNEL_TOP    = 24'h010101;
    localparam logic [KERNEL_W-1:0] RST_KERNEL_MID    = 24'h000000;
    localparam logic [KERNEL_W-1:0] RST_KERNEL_BOTTOM = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS,
        CFG_IMAGE_COLS,
        CFG_KERNEL_TOP,
        CFG_KERNEL_MID,
        CFG_KERNEL_BOTTOM
    } t_cfg_idx;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] result_pixel;
        logic             frame_last;
    } t_out;

    typedef struct packed {
        logic             have;
        logic             last;
        logic             row_ok_top;
        logic             row_ok_bot;
        logic             col_ok_left;
        logic             col_ok_right;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } t_cmd;

endpackage

FILE: hdl/c3zp_ram.sv
module c3zp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/c3zp_front.sv
module c3zp_front
    import c3zp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  t_in               i_item,
    input  logic [ROWS_W-1:0] i_rows,
    input  logic [COLS_W-1:0] i_cols,
    output logic              o_cmd_push,
    output t_cmd              o_cmd,
    input  logic              i_cmd_full
);

    logic [ROWS_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W-1:0] cols_eff;
    logic              accept, inframe, ignore, take, primed;
    logic              in_wrap, out_wrap, row_end, last;

    always_comb begin
        rows_eff = (i_rows == '0) ? ROWS_W'(1) : i_rows;
        if (i_cols == '0) begin
            cols_eff = COLS_W'(1);
        end else if (i_cols > MAX_COLS) begin
            cols_eff = COLS_W'(MAX_COLS);
        end else begin
            cols_eff = i_cols;
        end
    end

    assign accept   = i_push && !i_cmd_full;
    assign inframe  = r_in_row < rows_eff;
    assign ignore   = i_item.mode && inframe;
    assign take     = accept && !ignore;
    assign primed   = (r_in_row >= ROWS_W'(2)) ||
                      ((r_in_row == ROWS_W'(1)) && (r_in_col != '0));
    assign in_wrap  = ({1'b0, r_in_col} + 1'b1) >= cols_eff;
    assign out_wrap = ({1'b0, r_out_col} + 1'b1) >= cols_eff;
    assign row_end  = ({1'b0, r_out_row} + 1'b1) >= {1'b0, rows_eff};
    assign last     = row_end && out_wrap;

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (take) begin
            if (in_wrap) begin
                n_in_col = '0;
                if (r_in_row != '1) begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (primed) begin
                if (out_wrap) begin
                    n_out_col = '0;
                    if (r_out_row != '1) begin
                        n_out_row = r_out_row + 1'b1;
                    end
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
                if (last) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    always_comb begin
        o_cmd.have         = primed;
        o_cmd.last         = last;
        o_cmd.row_ok_top   = r_out_row != '0;
        o_cmd.row_ok_bot   = !row_end;
        o_cmd.col_ok_left  = r_out_col != '0;
        o_cmd.col_ok_right = !out_wrap && (r_in_col != '0);
        o_cmd.col          = r_in_col;
        o_cmd.pixel        = inframe ? i_item.pixel : '0;
    end

    assign o_cmd_push = take;
    assign o_full     = i_cmd_full;

endmodule

FILE: hdl/c3zp_cmd_queue.sv
module c3zp_cmd_queue
    import c3zp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push, do_pop;

    assign o_full  = r_count == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/c3zp_back.sv
module c3zp_back
    import c3zp_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [KROWS-1:0][KERNEL_W-1:0] i_kernel,
    input  t_cmd                           i_cmd,
    input  logic                           i_cmd_empty,
    output logic                           o_cmd_pop,
    output logic                           o_empty,
    input  logic                           i_pop,
    output t_out                           o_result
);

    t_cmd                           r_s1;
    logic                           r_s1_v;
    logic [2*PIX_W-1:0]             rdata, line_word, wdata;
    logic                           r_fw_v;
    logic [COL_W-1:0]               r_fw_addr;
    logic [2*PIX_W-1:0]             r_fw_data;
    logic                           fw_hit;
    logic [KROWS-1:0][PIX_W-1:0]    new_col;
    logic [KROWS-1:0][1:0][PIX_W-1:0] r_win;
    logic [KROWS-1:0]               row_ok, col_ok;
    logic [PIX_W-1:0]               tap;
    logic signed [PROD_W-1:0]       prod   [KROWS][KROWS];
    logic signed [PROD_W-1:0]       r_prod [KROWS][KROWS];
    logic                           r_s2_v, r_s2_have, r_s2_last;
    logic signed [SUM_W-1:0]        row_sum [KROWS];
    logic signed [SUM_W-1:0]        acc;
    t_out                           res;
    logic [OQ_SUM_W-1:0]            pending;
    t_out                           r_oq [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]          r_oq_wptr, r_oq_rptr;
    logic [OUTQ_CNT_W-1:0]          r_oq_count;
    logic                           oq_push, oq_pop;

    // hold back the command queue unless every result in flight has a slot
    assign pending = OQ_SUM_W'(r_oq_count) + OQ_SUM_W'(r_s1_v && r_s1.have) +
                     OQ_SUM_W'(r_s2_v && r_s2_have);
    assign o_cmd_pop = !i_cmd_empty && (pending < OQ_SUM_W'(OUTQ_DEPTH));

    c3zp_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1.col),
        .i_wdata (wdata),
        .i_re    (o_cmd_pop),
        .i_raddr (i_cmd.col),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1 <= i_cmd;
        end
        r_fw_addr <= r_s1.col;
        r_fw_data <= wdata;
    end

    // upper byte: row two back, lower byte: previous row
    assign fw_hit    = r_fw_v && (r_fw_addr == r_s1.col);
    assign line_word = fw_hit ? r_fw_data : rdata;
    assign wdata     = {line_word[PIX_W-1:0], r_s1.pixel};

    always_comb begin
        new_col[0] = line_word[2*PIX_W-1:PIX_W];
        new_col[1] = line_word[PIX_W-1:0];
        new_col[2] = r_s1.pixel;
        row_ok     = {r_s1.row_ok_bot, 1'b1, r_s1.row_ok_top};
        col_ok     = {r_s1.col_ok_right, 1'b1, r_s1.col_ok_left};
    end

    always_comb begin
        for (int r = 0; r < KROWS; r++) begin
            for (int j = 0; j < KROWS; j++) begin
                tap = (j == KROWS - 1) ? new_col[r] : r_win[r][j];
                if (row_ok[r] && col_ok[j]) begin
                    prod[r][j] = $signed({1'b0, tap}) *
                                 $signed(i_kernel[r][j*PIX_W +: PIX_W]);
                end else begin
                    prod[r][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_v) begin
            for (int r = 0; r < KROWS; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= new_col[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= prod;
        r_s2_have <= r_s1.have;
        r_s2_last <= r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fw_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= o_cmd_pop;
            r_fw_v <= r_s1_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_comb begin
        for (int r = 0; r < KROWS; r++) begin
            row_sum[r] = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]) + SUM_W'(r_prod[r][2]);
        end
        acc = row_sum[0] + row_sum[1] + row_sum[2];
        if (acc[SUM_W-1]) begin
            res.result_pixel = '0;
        end else if (acc > $signed(SUM_W'(PIX_MAX))) begin
            res.result_pixel = PIX_W'(PIX_MAX);
        end else begin
            res.result_pixel = acc[PIX_W-1:0];
        end
        res.frame_last = r_s2_last;
    end

    assign oq_push  = r_s2_v && r_s2_have;
    assign o_empty  = r_oq_count == '0;
    assign oq_pop   = i_pop && !o_empty;
    assign o_result = r_oq[r_oq_rptr];

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr  <= '0;
            r_oq_rptr  <= '0;
            r_oq_count <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wptr <= (r_oq_wptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ?
                             '0 : r_oq_wptr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rptr <= (r_oq_rptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ?
                             '0 : r_oq_rptr + 1'b1;
            end
            if (oq_push && !oq_pop) begin
                r_oq_count <= r_oq_count + 1'b1;
            end else if (oq_pop && !oq_push) begin
                r_oq_count <= r_oq_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/conv3x3_zero_pad_clamp.sv
// Streaming 3x3 convolution over 8-bit grayscale pixels in raster order.
// Input queue side: drive i_item and raise push; a beat is taken on a clock
// edge with push high and full low. mode 0 carries a pixel, mode 1 is a
// drain beat that flushes the results still owed after the last pixel.
// Result queue side: o_result holds the oldest result while empty is low;
// pop with empty low takes it. frame_last marks the final result of a frame.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (rows,
// cols, top, middle, bottom kernel row); write only while the block is idle.
// Throughput: one beat per cycle while full is low, set by the single line-store
// RAM that is read once and written once per beat through the back pipeline.
// A result is owed once the pixel one row and one column past its center
// arrives; it passes the command queue and back pipeline to the result queue.
// When pop stays low, the 4-entry result queue fills, the back pipeline
// stops draining the 4-entry command queue, and full rises once that fills.
// Reset (synchronous, i_rst_n low) clears counters, window, queues and loads
// the default registers; line-store contents are not cleared.
module conv3x3_zero_pad_clamp
    import c3zp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in                   i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out                  o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ROWS_W-1:0]              r_image_rows;
    logic [COLS_W-1:0]              r_image_cols;
    logic [KROWS-1:0][KERNEL_W-1:0] r_kernel;
    logic                           cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_cmd                           cmd_in, cmd_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= RST_IMAGE_ROWS;
            r_image_cols <= RST_IMAGE_COLS;
            r_kernel[0]  <= RST_KERNEL_TOP;
            r_kernel[1]  <= RST_KERNEL_MID;
            r_kernel[2]  <= RST_KERNEL_BOTTOM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_ROWS:    r_image_rows <= i_cfg_data[ROWS_W-1:0];
                CFG_IMAGE_COLS:    r_image_cols <= i_cfg_data[COLS_W-1:0];
                CFG_KERNEL_TOP:    r_kernel[0]  <= i_cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_MID:    r_kernel[1]  <= i_cfg_data[KERNEL_W-1:0];
                CFG_KERNEL_BOTTOM: r_kernel[2]  <= i_cfg_data[KERNEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    c3zp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_rows     (r_image_rows),
        .i_cols     (r_image_cols),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    c3zp_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_head),
        .o_empty (cmd_empty)
    );

    c3zp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kernel    (r_kernel),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
